### sv/rbs_pkg.sv
// rbs_pkg: shared defaults and lane status type for the ray/box slab test
// no dependencies
`timescale 1ns / 1ps
package rbs_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int AXES            = 3;

	typedef struct packed {
		logic moving;
		logic empty;
	} lane_flags_t;
endpackage

### sv/rbs_if.sv
// rbs_in_if / rbs_out_if: valid/ready channels for rays and results
// depends on rbs_pkg
`timescale 1ns / 1ps
interface rbs_in_if #(parameter int W = rbs_pkg::COORD_WIDTH_DEF) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] origin_x, origin_y, origin_z;
	logic signed [W-1:0] dir_x, dir_y, dir_z;
	logic signed [W-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [W-1:0] box_max_x, box_max_y, box_max_z;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbs_out_if #(parameter int W = rbs_pkg::COORD_WIDTH_DEF) ();
	logic valid;
	logic ready;
	logic hit_status;
	logic signed [W-1:0] entry_distance, exit_distance, best_distance;
	modport source(output valid, hit_status, entry_distance, exit_distance, best_distance,
		input ready);
	modport sink(input valid, hit_status, entry_distance, exit_distance, best_distance,
		output ready);
endinterface

### sv/rbs_div_pipe.sv
// rbs_div_pipe: pipelined restoring unsigned divider, one quotient bit per stage
// no dependencies
`timescale 1ns / 1ps
module rbs_div_pipe #(
	parameter int NW = 49,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [DW-1:0] rem_q [NW];
	logic [NW-1:0] quo_q [NW];
	logic [NW-1:0] num_q [NW];
	logic [DW-1:0] den_q [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] r_in, d_in;
		logic [NW-1:0] q_in, n_in;
		logic [DW:0]   trial, diff;
		logic          ge;
		if (k == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign n_in = num;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign q_in = quo_q[k-1];
			assign n_in = num_q[k-1];
			assign d_in = den_q[k-1];
		end
		assign trial = {r_in, n_in[NW-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = (trial >= {1'b0, d_in});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_q[k] <= {q_in[NW-2:0], ge};
				num_q[k] <= n_in << 1;
				den_q[k] <= d_in;
			end
		end
	end

	assign quo = quo_q[NW-1];
endmodule

### sv/rbs_lane.sv
// rbs_lane: one axis of the slab test, two plane divisions and ordering
// depends on rbs_pkg, rbs_div_pipe
`timescale 1ns / 1ps
module rbs_lane #(
	parameter int W = rbs_pkg::COORD_WIDTH_DEF,
	parameter int F = rbs_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] p,
	input  logic signed [W-1:0] d,
	input  logic signed [W-1:0] lo,
	input  logic signed [W-1:0] hi,
	output logic signed [W-1:0] entry_s2,
	output logic signed [W-1:0] exit_s2,
	output rbs_pkg::lane_flags_t flags_s2
);
	localparam int NW = W + 1 + F;

	typedef struct packed {
		logic neg_lo;
		logic neg_hi;
		logic zero;
		logic in_slab;
	} side_t;

	logic signed [W:0] diff_lo, diff_hi;
	logic [W:0]        mag_lo_s1, mag_hi_s1;
	logic [W-1:0]      mag_d_s1;
	side_t             side_s1;
	side_t             side_q [NW];
	logic [NW-1:0]     q_lo, q_hi;

	assign diff_lo = (W+1)'(lo) - (W+1)'(p);
	assign diff_hi = (W+1)'(hi) - (W+1)'(p);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_lo_s1       <= diff_lo[W] ? -diff_lo : diff_lo;
			mag_hi_s1       <= diff_hi[W] ? -diff_hi : diff_hi;
			mag_d_s1        <= d[W-1] ? -d : d;
			side_s1.neg_lo  <= diff_lo[W] ^ d[W-1];
			side_s1.neg_hi  <= diff_hi[W] ^ d[W-1];
			side_s1.zero    <= (d == '0);
			side_s1.in_slab <= (lo <= p) && (p <= hi);
		end
	end

	rbs_div_pipe #(.NW(NW), .DW(W)) u_div_lo (
		.clk(clk), .en(en), .num(NW'(mag_lo_s1) << F), .den(mag_d_s1), .quo(q_lo));
	rbs_div_pipe #(.NW(NW), .DW(W)) u_div_hi (
		.clk(clk), .en(en), .num(NW'(mag_hi_s1) << F), .den(mag_d_s1), .quo(q_hi));

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s1;
			for (int i = 1; i < NW; i++) side_q[i] <= side_q[i-1];
		end
	end

	function automatic logic signed [W-1:0] sat(input logic [NW-1:0] q, input logic neg);
		logic [NW-1:0] signb;
		logic [W-1:0]  qmin;
		signb = NW'(1) << (W - 1);
		qmin  = W'(1) << (W - 1);
		if (q >= signb) return neg ? qmin : ~qmin;
		return neg ? -q[W-1:0] : q[W-1:0];
	endfunction

	logic signed [W-1:0] u0, u1;
	side_t sd;
	assign sd = side_q[NW-1];
	assign u0 = sat(q_lo, sd.neg_lo);
	assign u1 = sat(q_hi, sd.neg_hi);

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd.zero) begin
				entry_s2 <= {1'b1, {(W-1){1'b0}}};
				exit_s2  <= {1'b0, {(W-1){1'b1}}};
			end else if (u0 > u1) begin
				entry_s2 <= u1;
				exit_s2  <= u0;
			end else begin
				entry_s2 <= u0;
				exit_s2  <= u1;
			end
			flags_s2.moving <= !sd.zero;
			flags_s2.empty  <= sd.zero && !sd.in_slab;
		end
	end
endmodule

### sv/rbs_merge.sv
// rbs_merge: combines the three axis intervals into hit and distances
// depends on rbs_pkg
`timescale 1ns / 1ps
module rbs_merge #(
	parameter int W = rbs_pkg::COORD_WIDTH_DEF
) (
	input  logic signed [W-1:0]  entry [rbs_pkg::AXES],
	input  logic signed [W-1:0]  exits [rbs_pkg::AXES],
	input  rbs_pkg::lane_flags_t flags [rbs_pkg::AXES],
	output logic                 hit,
	output logic signed [W-1:0]  t0,
	output logic signed [W-1:0]  t1,
	output logic signed [W-1:0]  best
);
	logic signed [W-1:0] mx, mn;
	logic moving, empty;

	always_comb begin
		mx = entry[0];
		mn = exits[0];
		moving = flags[0].moving;
		empty  = flags[0].empty;
		for (int a = 1; a < rbs_pkg::AXES; a++) begin
			if (entry[a] > mx) mx = entry[a];
			if (exits[a] < mn) mn = exits[a];
			moving |= flags[a].moving;
			empty  |= flags[a].empty;
		end
		t0 = empty ? {1'b0, {(W-1){1'b1}}} : mx;
		t1 = empty ? {1'b1, {(W-1){1'b0}}} : mn;
		hit  = 1'b0;
		best = '0;
		if (moving && t0 <= t1) begin
			priority if (!t0[W-1]) begin
				hit = 1'b1; best = t0;
			end else if (!t1[W-1]) begin
				hit = 1'b1; best = t1;
			end
		end
	end
endmodule

### sv/ray_box_slab_intersect.sv
// ray_box_slab_intersect: top level, three axis lanes, merge and output register
// depends on rbs_pkg, rbs_if, rbs_lane, rbs_merge
`timescale 1ns / 1ps
// Takes one ray/box beat per cycle unless stalled and returns one result beat
// per ray, in order, through an input register, the per-axis restoring dividers
// (one quotient bit per stage), a lane result register and the output register;
// the whole pipeline holds while a finished result waits at the output register.
module ray_box_slab_intersect #(
	parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rbs_in_if.sink    in_ch,
	rbs_out_if.source out_ch
);
	localparam int W   = COORD_WIDTH;
	localparam int LAT = COORD_WIDTH + FRAC_BITS + 3;
	localparam int A   = rbs_pkg::AXES;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [W-1:0] p [A], d [A], lo [A], hi [A];
	logic signed [W-1:0] ent [A], ext [A];
	rbs_pkg::lane_flags_t flg [A];
	logic hit;
	logic signed [W-1:0] t0, t1, best;
	logic out_valid_q, hit_q;
	logic signed [W-1:0] t0_q, t1_q, best_q;

	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	assign p  = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z};
	assign d  = '{in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};
	assign lo = '{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z};
	assign hi = '{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z};

	for (genvar a = 0; a < A; a++) begin : g_lane
		rbs_lane #(.W(W), .F(FRAC_BITS)) u_lane (
			.clk(clk), .en(en), .p(p[a]), .d(d[a]), .lo(lo[a]), .hi(hi[a]),
			.entry_s2(ent[a]), .exit_s2(ext[a]), .flags_s2(flg[a]));
	end

	rbs_merge #(.W(W)) u_merge (
		.entry(ent), .exits(ext), .flags(flg), .hit(hit), .t0(t0), .t1(t1), .best(best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], in_ch.valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit;
			t0_q   <= t0;
			t1_q   <= t1;
			best_q <= best;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.hit_status     = hit_q;
	assign out_ch.entry_distance = t0_q;
	assign out_ch.exit_distance  = t1_q;
	assign out_ch.best_distance  = best_q;
endmodule

### sv/rbs_checker.sv
// rbs_checker: port-level checks on result beats, bound to the top level
// depends on ray_box_slab_intersect
`timescale 1ns / 1ps
module rbs_checker #(
	parameter int W = rbs_pkg::COORD_WIDTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                hit_status,
	input logic signed [W-1:0] entry_distance,
	input logic signed [W-1:0] exit_distance,
	input logic signed [W-1:0] best_distance
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_distance)
		&& $stable(hit_status))
		else $error("stalled result beat changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_status |-> entry_distance <= exit_distance)
		else $error("hit with entry past exit");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_status |-> best_distance == '0)
		else $error("miss with nonzero best distance");

	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_status |-> !best_distance[W-1]
		&& (best_distance == entry_distance || best_distance == exit_distance))
		else $error("best distance not a nonnegative bound");
endmodule

bind ray_box_slab_intersect rbs_checker #(.W(COORD_WIDTH)) u_rbs_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.hit_status(out_ch.hit_status), .entry_distance(out_ch.entry_distance),
	.exit_distance(out_ch.exit_distance), .best_distance(out_ch.best_distance));

### tb/testbench.sv
// testbench: random and directed ray/box beats against a slab-test predictor
// depends on rbs_pkg, rbs_if and ray_box_slab_intersect
`timescale 1ns / 1ps
module testbench;
	localparam int W = rbs_pkg::COORD_WIDTH_DEF;
	localparam int F = rbs_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = W + F + 4;
	localparam longint QMAX = (64'sd1 <<< (W - 1)) - 1;
	localparam longint QMIN = -QMAX - 1;

	typedef struct {
		logic signed [W-1:0] f [12];
		bit drain;
	} ray_t;

	typedef struct {
		logic hit;
		logic signed [W-1:0] t_entry, t_exit, t_best;
	} hit_t;

	logic clk = 0;
	logic arst_n = 0;
	int fails = 0;
	int gap = 0;
	int burst = 0;
	int cyc = 0;
	ray_t pending [$];
	hit_t expected_hits [$];
	ray_t cur;

	rbs_in_if #(.W(W)) in_ch ();
	rbs_out_if #(.W(W)) out_ch ();

	ray_box_slab_intersect #(.COORD_WIDTH(W), .FRAC_BITS(F)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #4 clk = ~clk;

	function automatic longint slab_param(longint num, longint den);
		bit neg;
		longint unsigned mn, md, q;
		neg = (num < 0) != (den < 0);
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		q = (mn << F) / md;
		if (neg)
			return q >= (64'd1 << (W - 1)) ? QMIN : -longint'(q);
		return q > QMAX ? QMAX : longint'(q);
	endfunction

	function automatic hit_t slab_hit(ray_t r);
		hit_t h;
		longint t0, t1, p, d, lo, hi, u0, u1, s;
		bit moving;
		t0 = QMIN;
		t1 = QMAX;
		moving = 0;
		for (int a = 0; a < 3; a++) begin
			p = r.f[a];
			d = r.f[3 + a];
			lo = r.f[6 + a];
			hi = r.f[9 + a];
			if (d == 0) begin
				if (!(lo <= p && p <= hi)) begin
					t0 = QMAX;
					t1 = QMIN;
				end
			end else begin
				moving = 1;
				u0 = slab_param(lo - p, d);
				u1 = slab_param(hi - p, d);
				if (u0 > u1) begin
					s = u0;
					u0 = u1;
					u1 = s;
				end
				if (u0 > t0) t0 = u0;
				if (u1 < t1) t1 = u1;
			end
		end
		h.hit = moving && t0 <= t1 && (t0 >= 0 || t1 >= 0);
		h.t_entry = t0[W-1:0];
		h.t_exit = t1[W-1:0];
		h.t_best = !h.hit ? '0 : (t0 >= 0 ? t0[W-1:0] : t1[W-1:0]);
		return h;
	endfunction

	function automatic logic signed [W-1:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? QMAX[W-1:0] : QMIN[W-1:0];
			2: return $signed($urandom_range(0, 255)) - 128;
			default: return ($signed($urandom_range(0, 40 << F)) - (20 << F));
		endcase
	endfunction

	function automatic ray_t rnd_ray();
		ray_t r;
		logic signed [W-1:0] s;
		r.drain = 0;
		for (int i = 0; i < 12; i++) r.f[i] = $urandom;
		if ($urandom_range(0, 9) < 7) begin
			for (int a = 0; a < 3; a++) begin
				r.f[a] = rnd_coord();
				r.f[3 + a] = $urandom_range(0, 5) == 0 ? '0 : rnd_coord();
				r.f[6 + a] = rnd_coord();
				r.f[9 + a] = rnd_coord();
				if ($urandom_range(0, 7) != 0 && r.f[6 + a] > r.f[9 + a]) begin
					s = r.f[6 + a];
					r.f[6 + a] = r.f[9 + a];
					r.f[9 + a] = s;
				end
			end
		end
		return r;
	endfunction

	function automatic ray_t mk(logic signed [W-1:0] o, logic signed [W-1:0] d,
			logic signed [W-1:0] lo, logic signed [W-1:0] hi);
		ray_t r;
		r.drain = 0;
		for (int a = 0; a < 3; a++) begin
			r.f[a] = o;
			r.f[3 + a] = d;
			r.f[6 + a] = lo;
			r.f[9 + a] = hi;
		end
		return r;
	endfunction

	initial begin
		ray_t r;
		in_ch.valid = 0;
		out_ch.ready = 0;
		for (int i = 0; i < 12; i++) cur.f[i] = '0;
		{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
		{in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
		{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} = '0;
		{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} = '0;
		// directed: hits, inside start, behind, zero axes, saturation, extremes
		pending.push_back(mk(-(5 << F), 1 << F, 0, 2 << F));
		pending.push_back(mk(1 << F, 1 << F, 0, 2 << F));
		pending.push_back(mk(5 << F, 1 << F, 0, 2 << F));
		pending.push_back(mk(5 << F, -(1 << F), 0, 2 << F));
		pending.push_back(mk(-(5 << F), 1 << F, 2 << F, 0));
		pending.push_back(mk(1 << F, 0, 0, 2 << F));
		pending.push_back(mk(5 << F, 0, 0, 2 << F));
		pending.push_back(mk(QMIN[W-1:0], 1, QMAX[W-1:0], QMAX[W-1:0]));
		pending.push_back(mk(QMAX[W-1:0], 1, QMIN[W-1:0], QMIN[W-1:0]));
		pending.push_back(mk(QMAX[W-1:0], QMIN[W-1:0], QMIN[W-1:0], QMAX[W-1:0]));
		pending.push_back(mk(QMIN[W-1:0], QMAX[W-1:0], QMIN[W-1:0], QMAX[W-1:0]));
		pending.push_back(mk('1, '1, '1, '1));
		pending.push_back(mk(0, -1, -(3 << F), 3 << F));
		r = mk(0, 1 << F, -(1 << F), 1 << F);
		r.f[4] = 0;
		pending.push_back(r);
		r.f[1] = 9 << F;
		pending.push_back(r);
		r = mk(0, 1 << F, 2 << F, 4 << F);
		r.f[4] = -(1 << F);
		r.f[7] = -(9 << F);
		r.f[10] = -(8 << F);
		pending.push_back(r);
		r = mk(0, 1 << F, 2 << F, 4 << F);
		r.f[5] = 1;
		pending.push_back(r);
		for (int i = 0; i < 600; i++) begin
			r = rnd_ray();
			r.drain = (i % 150) == 75;
			pending.push_back(r);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0 && !in_ch.valid && expected_hits.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fails == 0 && expected_hits.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_hits.push_back(slab_hit(cur));
			if (!in_ch.valid || in_ch.ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_ch.valid <= 0;
				end else if (pending.size() == 0 ||
						(pending[0].drain && (expected_hits.size() != 0 ||
						(in_ch.valid && in_ch.ready)))) begin
					in_ch.valid <= 0;
				end else begin
					cur = pending.pop_front();
					{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} <=
						{cur.f[0], cur.f[1], cur.f[2]};
					{in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} <= {cur.f[3], cur.f[4], cur.f[5]};
					{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} <=
						{cur.f[6], cur.f[7], cur.f[8]};
					{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} <=
						{cur.f[9], cur.f[10], cur.f[11]};
					in_ch.valid <= 1;
					if (burst > 0) begin
						burst <= burst - 1;
					end else begin
						burst <= $urandom_range(0, 30);
						gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		hit_t h;
		cyc <= cyc + 1;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			case ((cyc / 256) % 3)
				0: out_ch.ready <= 1;
				1: out_ch.ready <= $urandom_range(0, 3) != 0;
				default: out_ch.ready <= (cyc % 7) < 2;
			endcase
			if (out_ch.valid && out_ch.ready) begin
				if (expected_hits.size() == 0) begin
					$error("result beat with nothing expected");
					fails = fails + 1;
				end else begin
					h = expected_hits.pop_front();
					if (out_ch.hit_status !== h.hit) begin
						$error("hit_status exp %0d got %0d", h.hit, out_ch.hit_status);
						fails = fails + 1;
					end
					if (out_ch.entry_distance !== h.t_entry) begin
						$error("entry_distance exp %0d got %0d", h.t_entry,
							out_ch.entry_distance);
						fails = fails + 1;
					end
					if (out_ch.exit_distance !== h.t_exit) begin
						$error("exit_distance exp %0d got %0d", h.t_exit, out_ch.exit_distance);
						fails = fails + 1;
					end
					if (out_ch.best_distance !== h.t_best) begin
						$error("best_distance exp %0d got %0d", h.t_best, out_ch.best_distance);
						fails = fails + 1;
					end
				end
			end
		end
	end
endmodule
